>>> design/bpsm_pkg.sv
package bpsm_pkg;

	localparam int NUM_SLOTS       = 32;
	localparam int NUM_DISK_BLOCKS = 8192;
	localparam int AGE_BITS        = 16;

	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TAG_W    = $clog2(NUM_DISK_BLOCKS);
	localparam int CMD_W    = 2;
	localparam int BLK_IN_W = 14;
	localparam int STAT_W   = 2;
	localparam int SLOT_O_W = 5;
	localparam int WB_O_W   = 13;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

	// one slot's metadata as held in the RAM; the valid bit lives in flops
	typedef struct packed {
		logic                dirty;
		logic [TAG_W-1:0]    tag;
		logic [AGE_BITS-1:0] age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/bpsm_ram.sv
module bpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/buffer_pool_slot_manager.sv
// Buffer pool slot manager, age-counter replacement.
// Command 3 or an out-of-bound block is answered from idle, one per cycle.
//   Allocate, lookup, mark dirty walk the metadata RAM, one entry per cycle
//   through its single read port, then pass the drain and finish steps; a new
//   transaction is taken only once the block is idle again.
// Reset: arst_n clears the slot valid bits and control state; RAM needs no pass.
// The receiver cannot stall: done pulses for one cycle with the result.
module buffer_pool_slot_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bpsm_pkg::CMD_W-1:0]    command,
	input  logic [bpsm_pkg::BLK_IN_W-1:0] block_num,
	output logic                          done,
	output logic [bpsm_pkg::STAT_W-1:0]   status,
	output logic [bpsm_pkg::SLOT_O_W-1:0] slot,
	output logic                          writeback_valid,
	output logic [bpsm_pkg::WB_O_W-1:0]   writeback_block
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	localparam logic [bpsm_pkg::SLOT_W-1:0] LAST_IDX =
		bpsm_pkg::SLOT_W'(bpsm_pkg::NUM_SLOTS - 1);

	state_t state_q;

	// latched transaction
	logic [bpsm_pkg::CMD_W-1:0] cmd_q;
	logic [bpsm_pkg::TAG_W-1:0] blk_q;

	// read issue counter and the stage that sees the read data
	logic [bpsm_pkg::SLOT_W-1:0] cnt_q;
	logic                        proc_vld_s1;
	logic [bpsm_pkg::SLOT_W-1:0] proc_idx_s1;

	// per-slot valid bits in flops; an invalid entry reads as clean, age 0
	logic [bpsm_pkg::NUM_SLOTS-1:0] valid_q;

	// allocate scan results
	logic                           free_found_q;
	logic [bpsm_pkg::SLOT_W-1:0]    free_idx_q;
	logic [bpsm_pkg::AGE_BITS-1:0]  max_age_q;
	logic [bpsm_pkg::SLOT_W-1:0]    max_idx_q;
	logic                           max_dirty_q;
	logic [bpsm_pkg::TAG_W-1:0]     max_tag_q;

	// lookup / mark scan results
	logic                           hit_q;
	logic [bpsm_pkg::SLOT_W-1:0]    hit_idx_q;
	logic [bpsm_pkg::AGE_BITS-1:0]  hit_age_q;

	// registered outputs
	logic                           done_q;
	logic [bpsm_pkg::STAT_W-1:0]    status_q;
	logic [bpsm_pkg::SLOT_O_W-1:0]  slot_q;
	logic                           wb_valid_q;
	logic [bpsm_pkg::WB_O_W-1:0]    wb_block_q;

	// RAM port
	logic                           ram_we;
	logic [bpsm_pkg::SLOT_W-1:0]    ram_waddr;
	bpsm_pkg::entry_t               ram_wdata;
	logic [bpsm_pkg::ENTRY_W-1:0]   ram_rdata;

	// data path of the scan stage
	bpsm_pkg::entry_t               rd_ent;
	logic                           rd_valid;
	logic                           rd_dirty;
	logic [bpsm_pkg::AGE_BITS-1:0]  rd_age;
	logic [bpsm_pkg::AGE_BITS-1:0]  aged;
	logic                           tag_hit;
	logic [bpsm_pkg::SLOT_W-1:0]    pick_idx;
	logic                           is_finish;
	logic                           oob;

	bpsm_ram #(
		.WIDTH (bpsm_pkg::ENTRY_W),
		.DEPTH (bpsm_pkg::NUM_SLOTS)
	) u_meta_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign writeback_valid = wb_valid_q;
	assign writeback_block = wb_block_q;

	// wide compare so the bound works even when it does not fit the input width
	assign oob = ({1'b0, block_num} >= (bpsm_pkg::BLK_IN_W + 1)'(bpsm_pkg::NUM_DISK_BLOCKS));

	always_comb begin
		rd_ent   = bpsm_pkg::entry_t'(ram_rdata);
		rd_valid = valid_q[proc_idx_s1];
		rd_dirty = rd_valid & rd_ent.dirty;
		rd_age   = rd_valid ? rd_ent.age : '0;
		// aging saturates; free slots do not age
		aged     = (rd_valid && (rd_age != bpsm_pkg::AGE_MAX)) ?
			rd_age + 1'b1 : rd_age;
		tag_hit  = rd_valid && (rd_ent.tag == blk_q);
		pick_idx = free_found_q ? free_idx_q : max_idx_q;
		is_finish = (state_q == S_FINISH);
	end

	// One write port: the scan writes back aged entries; FINISH writes the
	// claimed or marked entry. They never overlap, and each scan write goes to
	// the entry whose read data is in the scan stage, never to the one being read.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = proc_idx_s1;
		ram_wdata = '{dirty: rd_dirty, tag: rd_ent.tag, age: aged};
		if (is_finish) begin
			if (cmd_q == bpsm_pkg::CMD_ALLOC) begin
				ram_we    = 1'b1;
				ram_waddr = pick_idx;
				ram_wdata = '{dirty: 1'b0, tag: blk_q, age: '0};
			end else if (cmd_q == bpsm_pkg::CMD_MARK && hit_q) begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = '{dirty: 1'b1, tag: blk_q, age: hit_age_q};
			end
		end else if (proc_vld_s1 && cmd_q == bpsm_pkg::CMD_ALLOC && rd_valid) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= bpsm_pkg::CMD_NOP;
			blk_q        <= '0;
			cnt_q        <= '0;
			proc_vld_s1  <= 1'b0;
			proc_idx_s1  <= '0;
			valid_q      <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			max_age_q    <= '0;
			max_idx_q    <= '0;
			max_dirty_q  <= 1'b0;
			max_tag_q    <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_age_q    <= '0;
			done_q       <= 1'b0;
			status_q     <= bpsm_pkg::ST_OK;
			slot_q       <= '0;
			wb_valid_q   <= 1'b0;
			wb_block_q   <= '0;
		end else begin
			done_q      <= 1'b0;
			proc_vld_s1 <= 1'b0;

			// scan stage: one entry per cycle
			if (proc_vld_s1) begin
				if (cmd_q == bpsm_pkg::CMD_ALLOC) begin
					if (!rd_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= proc_idx_s1;
					end
					// strict greater keeps the lowest index on a tie
					if (proc_idx_s1 == '0 || aged > max_age_q) begin
						max_age_q   <= aged;
						max_idx_q   <= proc_idx_s1;
						max_dirty_q <= rd_dirty;
						max_tag_q   <= rd_ent.tag;
					end
				end else if (tag_hit && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= proc_idx_s1;
					hit_age_q <= rd_age;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == bpsm_pkg::CMD_NOP) begin
							done_q     <= 1'b1;
							status_q   <= bpsm_pkg::ST_OK;
							slot_q     <= '0;
							wb_valid_q <= 1'b0;
							wb_block_q <= '0;
						end else if (oob) begin
							done_q     <= 1'b1;
							status_q   <= bpsm_pkg::ST_OOB;
							slot_q     <= '0;
							wb_valid_q <= 1'b0;
							wb_block_q <= '0;
						end else begin
							cmd_q        <= command;
							blk_q        <= bpsm_pkg::TAG_W'(block_num);
							cnt_q        <= '0;
							free_found_q <= 1'b0;
							hit_q        <= 1'b0;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					proc_vld_s1 <= 1'b1;
					proc_idx_s1 <= cnt_q;
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (cmd_q == bpsm_pkg::CMD_ALLOC) begin
						valid_q[pick_idx] <= 1'b1;
						status_q   <= bpsm_pkg::ST_OK;
						slot_q     <= bpsm_pkg::SLOT_O_W'(pick_idx);
						// eviction only when every slot was occupied
						wb_valid_q <= !free_found_q && max_dirty_q;
						wb_block_q <= (!free_found_q && max_dirty_q) ?
							bpsm_pkg::WB_O_W'(max_tag_q) : '0;
					end else begin
						status_q   <= hit_q ? bpsm_pkg::ST_OK : bpsm_pkg::ST_MISS;
						slot_q     <= hit_q ? bpsm_pkg::SLOT_O_W'(hit_idx_q) : '0;
						wb_valid_q <= 1'b0;
						wb_block_q <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result that is not success carries slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != bpsm_pkg::ST_OK) |-> (slot == '0))
		else $error("slot nonzero on failed transaction");

	// writeback is only reported with a successful allocation result
	a_wb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && writeback_valid |-> (status == bpsm_pkg::ST_OK))
		else $error("writeback outside a successful result");

	// scan data never arrives outside the walk over the RAM
	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		proc_vld_s1 |-> (state_q == S_SCAN) || (state_q == S_DRAIN))
		else $error("scan stage active outside the walk");

	// the finish step always produces exactly one result next cycle
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> done && !busy)
		else $error("finish without a result");

endmodule
